>>> hw/rtl/gtanh_pkg.sv
// ----------------------------------------------------------------------------
// gtanh_pkg
// Shared widths, constants and the tanh sample table of the GELU datapath.
// ----------------------------------------------------------------------------
package gtanh_pkg;

	localparam int SAMPLE_W         = 16;
	localparam int FRAC_BITS        = 12;
	localparam int TANH_TABLE_DEPTH = 256;

	localparam int Q20_SHIFT   = 20;
	localparam int K_SQRT_2_PI = 836643;
	localparam int KS_W        = 20;
	localparam int K_CUBIC     = 46887;
	localparam int KC_W        = 16;

	localparam int MAG_W       = SAMPLE_W;
	localparam int M2_W        = 2 * MAG_W;
	localparam int MK_W        = MAG_W + KC_W;
	localparam int P3_W        = M2_W + MK_W;
	localparam int CUBE_SHIFT  = 2 * FRAC_BITS + Q20_SHIFT;
	localparam int CUB_W       = P3_W - CUBE_SHIFT;
	localparam int S_W         = CUB_W + 1;
	localparam int SK_W        = S_W + KS_W + 1;
	localparam int U_W         = SK_W - Q20_SHIFT;

	localparam int LIM_SH      = FRAC_BITS + 2;
	localparam int TANH_LIM    = 1 << LIM_SH;
	localparam int FR_W        = LIM_SH;
	localparam int DEPTH_W     = $clog2(TANH_TABLE_DEPTH + 1);
	localparam int NUM_W       = LIM_SH + DEPTH_W;

	localparam int TANH_W      = 17;
	localparam int TANH_ONE    = 65536;
	localparam int DIFF_W      = TANH_W + 1;
	localparam int DP_W        = DIFF_W + FR_W + 1;
	localparam int T_W         = TANH_W + 1;
	localparam int G_W         = TANH_W + 2;

	localparam int P_W         = SAMPLE_W + G_W;
	localparam int OUT_SH      = 17;
	localparam int Y_W         = P_W + 1 - OUT_SH;
	localparam int SAMPLE_MAX  = (1 << (SAMPLE_W - 1)) - 1;
	localparam int SAMPLE_MIN  = -(1 << (SAMPLE_W - 1));

	localparam longint unsigned EXP_ONE = 64'd1073741824;
	localparam longint unsigned TANH_H  = (64'd8 * EXP_ONE) / 64'(TANH_TABLE_DEPTH);
	localparam int TAYLOR_TERMS = 12;

	typedef logic [TANH_W-1:0] tanh_rom_t [TANH_TABLE_DEPTH+1];

	function automatic logic [MAG_W-1:0] abs_mag(logic signed [SAMPLE_W-1:0] v);
		logic [MAG_W-1:0] r;
		r = v[SAMPLE_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
		return r;
	endfunction

	// shift-and-subtract quotient for the table build
	function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned rem;
		q   = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], n[i]};
			if (rem >= d) begin
				rem  = rem - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh(4k/DEPTH) in Q16, built from an exp(-h) series and repeated products
	function automatic tanh_rom_t build_tanh_rom();
		tanh_rom_t        rom;
		longint unsigned  term;
		longint unsigned  d;
		longint unsigned  e;
		longint unsigned  ru;
		longint           r;
		term = EXP_ONE;
		r    = longint'(EXP_ONE);
		e    = EXP_ONE;
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			d    = 64'(n) * EXP_ONE;
			term = udiv64(term * TANH_H + d / 64'd2, d);
			if (n % 2 == 1) begin
				r = r - longint'(term);
			end else begin
				r = r + longint'(term);
			end
		end
		if (r < 0) begin
			r = 0;
		end
		ru = longint'(r);
		for (int k = 0; k <= TANH_TABLE_DEPTH; k++) begin
			if (k > 0) begin
				e = (e * ru + (EXP_ONE >> 1)) >> 30;
			end
			rom[k] = TANH_W'(udiv64(((EXP_ONE - e) << 16) + (EXP_ONE + e) / 64'd2,
				EXP_ONE + e));
		end
		return rom;
	endfunction

	localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

>>> hw/rtl/gtanh_arg.sv
// ----------------------------------------------------------------------------
// gtanh_arg
// Four-stage pipe forming u = sqrt(2/pi) * (|x| + 0.044715*|x|^3) in QF.
// ----------------------------------------------------------------------------
module gtanh_arg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 up_valid,
	output logic                                 up_ready,
	input  logic signed [gtanh_pkg::SAMPLE_W-1:0] x,
	output logic                                 dn_valid,
	input  logic                                 dn_ready,
	output logic signed [gtanh_pkg::SAMPLE_W-1:0] x_out,
	output logic        [gtanh_pkg::U_W-1:0]      u
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic signed [gtanh_pkg::SAMPLE_W-1:0] x_s1, x_s2, x_s3, x_s4;
	logic [gtanh_pkg::M2_W-1:0]            m2_s1;
	logic [gtanh_pkg::MK_W-1:0]            mk_s1;
	logic [gtanh_pkg::P3_W-1:0]            p3_s2;
	logic [gtanh_pkg::S_W-1:0]             s_s3;
	logic [gtanh_pkg::U_W-1:0]             u_s4;

	logic [gtanh_pkg::MAG_W-1:0]  mag1;
	logic [gtanh_pkg::MAG_W-1:0]  mag3;
	logic [gtanh_pkg::P3_W:0]     p3_rnd;
	logic [gtanh_pkg::CUB_W-1:0]  cub;
	logic [gtanh_pkg::SK_W-1:0]   sk;

	assign en_s4    = !v_s4 || dn_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign up_ready = en_s1;

	always_comb begin
		mag1   = gtanh_pkg::abs_mag(x);
		mag3   = gtanh_pkg::abs_mag(x_s2);
		p3_rnd = (gtanh_pkg::P3_W+1)'(p3_s2)
			+ ((gtanh_pkg::P3_W+1)'(1) << (gtanh_pkg::CUBE_SHIFT - 1));
		cub    = gtanh_pkg::CUB_W'(p3_rnd >> gtanh_pkg::CUBE_SHIFT);
		sk     = gtanh_pkg::SK_W'(s_s3) * gtanh_pkg::SK_W'(gtanh_pkg::K_SQRT_2_PI)
			+ (gtanh_pkg::SK_W'(1) << (gtanh_pkg::Q20_SHIFT - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= up_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1  <= x;
			m2_s1 <= gtanh_pkg::M2_W'(mag1) * gtanh_pkg::M2_W'(mag1);
			mk_s1 <= gtanh_pkg::MK_W'(mag1) * gtanh_pkg::MK_W'(gtanh_pkg::K_CUBIC);
		end
		if (en_s2) begin
			x_s2  <= x_s1;
			p3_s2 <= gtanh_pkg::P3_W'(m2_s1) * gtanh_pkg::P3_W'(mk_s1);
		end
		if (en_s3) begin
			x_s3 <= x_s2;
			s_s3 <= gtanh_pkg::S_W'(mag3) + gtanh_pkg::S_W'(cub);
		end
		if (en_s4) begin
			x_s4 <= x_s3;
			u_s4 <= gtanh_pkg::U_W'(sk >> gtanh_pkg::Q20_SHIFT);
		end
	end

	assign dn_valid = v_s4;
	assign x_out    = x_s4;
	assign u        = u_s4;

`ifndef NO_ASSERTIONS
	a_zero_arg: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && x_s4 == '0 |-> u_s4 == '0)
		else $error("nonzero tanh argument for zero sample");
	a_hold_arg: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !dn_ready |=> v_s4 && $stable(u_s4) && $stable(x_s4))
		else $error("argument stage moved while stalled");
`endif

endmodule

>>> hw/rtl/gtanh_interp.sv
// ----------------------------------------------------------------------------
// gtanh_interp
// Three-stage tanh lookup with linear interpolation, giving g = 1 + sign(x)*tanh(u).
// ----------------------------------------------------------------------------
module gtanh_interp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 up_valid,
	output logic                                 up_ready,
	input  logic signed [gtanh_pkg::SAMPLE_W-1:0] x,
	input  logic        [gtanh_pkg::U_W-1:0]      u,
	output logic                                 dn_valid,
	input  logic                                 dn_ready,
	output logic signed [gtanh_pkg::SAMPLE_W-1:0] x_out,
	output logic signed [gtanh_pkg::G_W-1:0]      g
);

	logic v_s5, v_s6, v_s7;
	logic en_s5, en_s6, en_s7;

	logic signed [gtanh_pkg::SAMPLE_W-1:0] x_s5, x_s6, x_s7;
	logic                                  sat_s5, sat_s6;
	logic [gtanh_pkg::TANH_W-1:0]          a_s5, b_s5, a_s6;
	logic [gtanh_pkg::FR_W-1:0]            fr_s5;
	logic signed [gtanh_pkg::DP_W-1:0]     dp_s6;
	logic signed [gtanh_pkg::G_W-1:0]      g_s7;

	logic                              sat;
	logic [gtanh_pkg::NUM_W-1:0]       num;
	logic [gtanh_pkg::DEPTH_W-1:0]     idx;
	logic [gtanh_pkg::DEPTH_W-1:0]     idx1;
	logic signed [gtanh_pkg::DIFF_W-1:0] diff;
	logic signed [gtanh_pkg::DP_W-1:0]   dq;
	logic signed [gtanh_pkg::DP_W-1:0]   dsh;
	logic signed [gtanh_pkg::T_W-1:0]    t;
	logic signed [gtanh_pkg::G_W-1:0]    gn;

	assign en_s7    = !v_s7 || dn_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign up_ready = en_s5;

	always_comb begin
		sat  = u >= gtanh_pkg::U_W'(gtanh_pkg::TANH_LIM);
		num  = gtanh_pkg::NUM_W'(u[gtanh_pkg::LIM_SH-1:0])
			* gtanh_pkg::NUM_W'(gtanh_pkg::TANH_TABLE_DEPTH);
		idx  = num[gtanh_pkg::NUM_W-1:gtanh_pkg::LIM_SH];
		if (idx >= gtanh_pkg::DEPTH_W'(gtanh_pkg::TANH_TABLE_DEPTH)) begin
			idx = gtanh_pkg::DEPTH_W'(gtanh_pkg::TANH_TABLE_DEPTH - 1);
		end
		idx1 = idx + 1'b1;
	end

	always_comb begin
		diff = $signed({1'b0, b_s5}) - $signed({1'b0, a_s5});
		dq   = dp_s6 + (dp_s6[gtanh_pkg::DP_W-1]
			? gtanh_pkg::DP_W'(gtanh_pkg::TANH_LIM - 1) : gtanh_pkg::DP_W'(0));
		dsh  = dq >>> gtanh_pkg::LIM_SH;
		t    = gtanh_pkg::T_W'(dsh) + $signed({1'b0, a_s6});
		if (sat_s6) begin
			t = gtanh_pkg::T_W'(gtanh_pkg::TANH_ONE);
		end
		if (x_s6[gtanh_pkg::SAMPLE_W-1]) begin
			gn = gtanh_pkg::G_W'(gtanh_pkg::TANH_ONE) - gtanh_pkg::G_W'(t);
		end else begin
			gn = gtanh_pkg::G_W'(gtanh_pkg::TANH_ONE) + gtanh_pkg::G_W'(t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= up_valid;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			x_s5   <= x;
			sat_s5 <= sat;
			a_s5   <= gtanh_pkg::TANH_ROM[idx];
			b_s5   <= gtanh_pkg::TANH_ROM[idx1];
			fr_s5  <= num[gtanh_pkg::LIM_SH-1:0];
		end
		if (en_s6) begin
			x_s6   <= x_s5;
			sat_s6 <= sat_s5;
			a_s6   <= a_s5;
			dp_s6  <= gtanh_pkg::DP_W'(diff) * $signed({1'b0, fr_s5});
		end
		if (en_s7) begin
			x_s7 <= x_s6;
			g_s7 <= gn;
		end
	end

	assign dn_valid = v_s7;
	assign x_out    = x_s7;
	assign g        = g_s7;

`ifndef NO_ASSERTIONS
	a_g_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> g_s7 >= 0 && g_s7 <= gtanh_pkg::G_W'(2 * gtanh_pkg::TANH_ONE))
		else $error("gain outside zero to two");
	a_g_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && !x_s7[gtanh_pkg::SAMPLE_W-1] |-> g_s7 >= gtanh_pkg::G_W'(gtanh_pkg::TANH_ONE))
		else $error("gain below one for nonnegative sample");
`endif

endmodule

>>> hw/rtl/gtanh_scale.sv
// ----------------------------------------------------------------------------
// gtanh_scale
// Two-stage output: x*g, round half up by 2^17, saturate to the sample range.
// ----------------------------------------------------------------------------
module gtanh_scale (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 up_valid,
	output logic                                 up_ready,
	input  logic signed [gtanh_pkg::SAMPLE_W-1:0] x,
	input  logic signed [gtanh_pkg::G_W-1:0]      g,
	output logic                                 dn_valid,
	input  logic                                 dn_ready,
	output logic signed [gtanh_pkg::SAMPLE_W-1:0] y
);

	logic v_s8, v_s9;
	logic en_s8, en_s9;

	logic signed [gtanh_pkg::P_W-1:0]      p_s8;
	logic                                  neg_s8;
	logic signed [gtanh_pkg::SAMPLE_W-1:0] y_s9;

	logic signed [gtanh_pkg::P_W:0]     pr;
	logic signed [gtanh_pkg::Y_W-1:0]   yw;
	logic signed [gtanh_pkg::SAMPLE_W-1:0] yc;

	assign en_s9    = !v_s9 || dn_ready;
	assign en_s8    = !v_s8 || en_s9;
	assign up_ready = en_s8;

	always_comb begin
		pr = (gtanh_pkg::P_W+1)'(p_s8) + (gtanh_pkg::P_W+1)'(1 << (gtanh_pkg::OUT_SH - 1));
		yw = gtanh_pkg::Y_W'(pr >>> gtanh_pkg::OUT_SH);
		if (yw > gtanh_pkg::Y_W'(gtanh_pkg::SAMPLE_MAX)) begin
			yc = gtanh_pkg::SAMPLE_W'(gtanh_pkg::SAMPLE_MAX);
		end else if (yw < gtanh_pkg::Y_W'(gtanh_pkg::SAMPLE_MIN)) begin
			yc = gtanh_pkg::SAMPLE_W'(gtanh_pkg::SAMPLE_MIN);
		end else begin
			yc = gtanh_pkg::SAMPLE_W'(yw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s8) v_s8 <= up_valid;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			p_s8   <= gtanh_pkg::P_W'(x) * gtanh_pkg::P_W'(g);
			neg_s8 <= x[gtanh_pkg::SAMPLE_W-1];
		end
		if (en_s9) begin
			y_s9 <= yc;
		end
	end

	assign dn_valid = v_s9;
	assign y        = y_s9;

`ifndef NO_ASSERTIONS
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		en_s9 && v_s8 && !neg_s8 |=> !y_s9[gtanh_pkg::SAMPLE_W-1])
		else $error("negative result for nonnegative sample");
	a_neg_prod: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && p_s8 < 0 |-> neg_s8)
		else $error("negative product for nonnegative sample");
`endif

endmodule

>>> hw/rtl/gelu_tanh_approximation_core.sv
// ----------------------------------------------------------------------------
// gelu_tanh_approximation_core: GELU, tanh form, Q4.12 in and out.
// Throughput: one word per cycle while out_ready is high.
// The nine pipeline registers each hold one word.
// Reset: arst_n clears all valid bits; the tanh table is constant, no clearing pass.
// ----------------------------------------------------------------------------
module gelu_tanh_approximation_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [gtanh_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [gtanh_pkg::SAMPLE_W-1:0] sample_out
);

	logic                                  arg_valid, arg_ready;
	logic signed [gtanh_pkg::SAMPLE_W-1:0] arg_x;
	logic [gtanh_pkg::U_W-1:0]             arg_u;

	logic                                  ip_valid, ip_ready;
	logic signed [gtanh_pkg::SAMPLE_W-1:0] ip_x;
	logic signed [gtanh_pkg::G_W-1:0]      ip_g;

	gtanh_arg u_arg (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.x        (sample_in),
		.dn_valid (arg_valid),
		.dn_ready (arg_ready),
		.x_out    (arg_x),
		.u        (arg_u)
	);

	gtanh_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (arg_valid),
		.up_ready (arg_ready),
		.x        (arg_x),
		.u        (arg_u),
		.dn_valid (ip_valid),
		.dn_ready (ip_ready),
		.x_out    (ip_x),
		.g        (ip_g)
	);

	gtanh_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (ip_valid),
		.up_ready (ip_ready),
		.x        (ip_x),
		.g        (ip_g),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.y        (sample_out)
	);

endmodule

>>> tb/sv/gelu_tanh_approximation_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gelu_tanh_approximation_core_tb
// Drives Q4.12 samples through the GELU core under random gaps on both sides
// and checks every output word against a bit-exact fixed-point GELU model
// built from its own tanh sample table, or a fixed value for some probes.
// ----------------------------------------------------------------------------
module gelu_tanh_approximation_core_tb;

	localparam int W            = gtanh_pkg::SAMPLE_W;
	localparam int FRAC         = gtanh_pkg::FRAC_BITS;
	localparam int TABLE_DEPTH  = gtanh_pkg::TANH_TABLE_DEPTH;
	localparam int RANDOM_WORDS = 1300;
	localparam int TAIL_CYCLES  = 20;

	localparam longint unsigned EXP_Q30 = 64'd1073741824;
	localparam longint SQRT_2_PI_Q20    = 64'sd836643;
	localparam longint CUBIC_Q20        = 64'sd46887;
	localparam longint TANH_UNIT        = 64'sd65536;

	typedef struct {
		logic signed [W-1:0] sample;
		bit                  fixed_want;
		logic signed [W-1:0] want;
	} probe_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic signed [W-1:0] sample_in;
	logic                out_valid;
	logic                out_ready;
	logic signed [W-1:0] sample_out;

	logic signed [W-1:0] sample_want;
	logic signed [W-1:0] gelu_expected [$];
	logic signed [W-1:0] next_want;
	longint              tanh_q16 [0:TABLE_DEPTH];
	int                  fail_count = 0;
	bit                  calm = 1'b0;

	probe_t probe_list [25] = '{
		'{16'sd0,      1'b1, 16'sd0},
		'{16'sd32767,  1'b1, 16'sd32767},
		'{16'sh8000,   1'b1, 16'sd0},
		'{-16'sd32767, 1'b1, 16'sd0},
		'{16'sd16384,  1'b1, 16'sd16384},
		'{-16'sd16384, 1'b1, 16'sd0},
		'{16'sh5555,   1'b1, 16'sd21845},
		'{16'shAAAA,   1'b1, 16'sd0},
		'{16'sd1,      1'b0, 16'sd0},
		'{-16'sd1,     1'b0, 16'sd0},
		'{16'sd2,      1'b0, 16'sd0},
		'{16'sd100,    1'b0, 16'sd0},
		'{-16'sd100,   1'b0, 16'sd0},
		'{16'sd2048,   1'b0, 16'sd0},
		'{-16'sd2048,  1'b0, 16'sd0},
		'{16'sd4096,   1'b0, 16'sd0},
		'{-16'sd4096,  1'b0, 16'sd0},
		'{16'sd8192,   1'b0, 16'sd0},
		'{-16'sd8192,  1'b0, 16'sd0},
		'{16'sd12288,  1'b0, 16'sd0},
		'{-16'sd12288, 1'b0, 16'sd0},
		'{16'sd13672,  1'b0, 16'sd0},
		'{16'sd13680,  1'b0, 16'sd0},
		'{16'sd13688,  1'b0, 16'sd0},
		'{-16'sd13680, 1'b0, 16'sd0}
	};

	gelu_tanh_approximation_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	always #4 clk = ~clk;

	// tanh(4k/DEPTH) in Q16 from an exp(-h) series and repeated products
	function automatic void build_tanh_points();
		longint unsigned step;
		longint unsigned term;
		longint unsigned den;
		longint unsigned ex;
		longint          r;
		step = (64'd8 * EXP_Q30) / 64'(TABLE_DEPTH);
		term = EXP_Q30;
		r    = longint'(EXP_Q30);
		ex   = EXP_Q30;
		for (int n = 1; n <= 12; n++) begin
			den  = 64'(n) * EXP_Q30;
			term = (term * step + den / 64'd2) / den;
			if (n % 2 == 1) begin
				r = r - longint'(term);
			end else begin
				r = r + longint'(term);
			end
		end
		if (r < 0) begin
			r = 0;
		end
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			if (k > 0) begin
				ex = (ex * longint'(r) + (EXP_Q30 >> 1)) >> 30;
			end
			tanh_q16[k] = longint'((((EXP_Q30 - ex) << 16) + (EXP_Q30 + ex) / 64'd2)
				/ (EXP_Q30 + ex));
		end
	endfunction

	function automatic logic signed [W-1:0] gelu_model(input logic signed [W-1:0] x);
		longint sx;
		longint mag;
		longint cube;
		longint arg;
		longint lim;
		longint num;
		longint idx;
		longint frac;
		longint th;
		longint g;
		longint y;
		sx   = x;
		mag  = (sx < 0) ? -sx : sx;
		cube = (mag * mag * mag * CUBIC_Q20 + (64'sd1 << (2 * FRAC + 19))) >>> (2 * FRAC + 20);
		arg  = ((mag + cube) * SQRT_2_PI_Q20 + (64'sd1 << 19)) >>> 20;
		lim  = 64'sd4 << FRAC;
		if (arg >= lim) begin
			th = TANH_UNIT;
		end else begin
			num  = arg * TABLE_DEPTH;
			idx  = num / lim;
			frac = num % lim;
			if (idx >= TABLE_DEPTH) begin
				idx = TABLE_DEPTH - 1;
			end
			th = tanh_q16[idx] + ((tanh_q16[idx+1] - tanh_q16[idx]) * frac) / lim;
		end
		g = TANH_UNIT + ((sx < 0) ? -th : th);
		y = ((sx * g + (64'sd1 << 16) + (64'sd1 << 34)) >>> 17) - (64'sd1 << 17);
		if (y > gtanh_pkg::SAMPLE_MAX) begin
			y = gtanh_pkg::SAMPLE_MAX;
		end
		if (y < gtanh_pkg::SAMPLE_MIN) begin
			y = gtanh_pkg::SAMPLE_MIN;
		end
		return W'(y);
	endfunction

	function automatic int pick_gap(input bit quiet);
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 60) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end else if (roll < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [W-1:0] random_sample();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			return W'($urandom_range(0, 65535));
		end else if (roll < 70) begin
			return W'($urandom_range(0, 40959) - 20480);
		end else if (roll < 85) begin
			return W'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(13500, 13900)));
		end
		return W'($urandom_range(0, 511) - 256);
	endfunction

	task automatic send_sample(input logic signed [W-1:0] v, input bit known,
		input logic signed [W-1:0] want, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sample_in   <= v;
		sample_want <= known ? want : gelu_model(v);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// hold input until every outstanding word has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (gelu_expected.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			gelu_expected.push_back(sample_want);
		end
		if (arst_n && out_valid && out_ready) begin
			if (gelu_expected.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected word, expected none actual %0d",
					$time, sample_out);
			end else begin
				next_want = gelu_expected.pop_front();
				if (sample_out !== next_want) begin
					fail_count++;
					$display("%0t: sample_out mismatch, expected %0d actual %0d",
						$time, next_want, sample_out);
				end
			end
		end
	end

	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int gap;
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			gap = pick_gap(calm);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		#8_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		sample_in   <= '0;
		sample_want <= '0;
		build_tanh_points();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (probe_list[k]) begin
			send_sample(probe_list[k].sample, probe_list[k].fixed_want,
				probe_list[k].want, pick_gap(1'b0));
		end
		drain();
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2) begin
				drain();
			end
			calm = ((n / 150) % 3) == 1;
			send_sample(random_sample(), 1'b0, '0, pick_gap(calm));
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/gtanh_pkg.sv
hw/rtl/gtanh_arg.sv
hw/rtl/gtanh_interp.sv
hw/rtl/gtanh_scale.sv
hw/rtl/gelu_tanh_approximation_core.sv
tb/sv/gelu_tanh_approximation_core_tb.sv
